// ===== rtl/gdjs_pkg.sv =====
// Shared types and defaults for the greedy deadline job sequencer.
`timescale 1ns / 1ps

package gdjs_pkg;

   localparam int MAX_JOBS_DEF  = 64;
   localparam int MAX_SLOTS_DEF = 64;

   typedef struct packed {
      logic [7:0]  job_id;
      logic [7:0]  job_deadline;
      logic [15:0] job_profit;
      logic        set_last;
   } req_type;

   typedef struct packed {
      logic [7:0] scheduled_id;
      logic [5:0] slot_index;
      logic       sequence_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  deadline;
      logic [15:0] profit;
   } job_entry_type;

   typedef struct packed {
      logic       taken;
      logic [7:0] owner;
   } slot_entry_type;

endpackage

// ===== rtl/gdjs_job_mem.sv =====
// Job storage: one write port at load time, one registered read port for the scan.
`timescale 1ns / 1ps

module gdjs_job_mem #(
   parameter int DEPTH = gdjs_pkg::MAX_JOBS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  gdjs_pkg::job_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output gdjs_pkg::job_entry_type rd_data
);

   gdjs_pkg::job_entry_type mem [DEPTH];
   gdjs_pkg::job_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gdjs_slot_mem.sv =====
// Slot table: taken flag and owner id per slot, single address, registered read.
`timescale 1ns / 1ps

module gdjs_slot_mem #(
   parameter int DEPTH = gdjs_pkg::MAX_SLOTS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            addr,
   input  gdjs_pkg::slot_entry_type wr_data,
   output gdjs_pkg::slot_entry_type rd_data
);

   gdjs_pkg::slot_entry_type mem [DEPTH];
   gdjs_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/greedy_deadline_job_sequencer_core.sv =====
// Top level: load jobs, pick them by descending profit, place them in slots, emit the schedule.
// Loading takes one request per cycle. After the request with set_last the input stalls through
// slot clearing, then N+1 selection scans over the N jobs held (keys compared on the job memory
// read data), each chosen job followed by a downward slot search from min(deadline, MAX_SLOTS)-1
// (none for deadline zero), then emission and flush, which also wait on output stalls.
// Synchronous active-high reset empties the job set and the output register.
`timescale 1ns / 1ps

module greedy_deadline_job_sequencer_core #(
   parameter int MAX_JOBS  = gdjs_pkg::MAX_JOBS_DEF,
   parameter int MAX_SLOTS = gdjs_pkg::MAX_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gdjs_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gdjs_pkg::rsp_type rsp_payload
);

   localparam int JW   = $clog2(MAX_JOBS);
   localparam int CW   = $clog2(MAX_JOBS + 1);
   localparam int SW   = $clog2(MAX_SLOTS);
   localparam int KW   = 16 + JW;
   localparam int DLW  = ($clog2(MAX_SLOTS + 1) > 8) ? $clog2(MAX_SLOTS + 1) : 8;
   localparam int SIW  = (SW > 6) ? SW : 6;

   typedef enum logic [9:0] {
      S_LOAD     = 10'b00_0000_0001,
      S_CLEAR    = 10'b00_0000_0010,
      S_SCAN_RD  = 10'b00_0000_0100,
      S_SCAN_CHK = 10'b00_0000_1000,
      S_PLACE    = 10'b00_0001_0000,
      S_SLOT_RD  = 10'b00_0010_0000,
      S_SLOT_CHK = 10'b00_0100_0000,
      S_EMIT_RD  = 10'b00_1000_0000,
      S_EMIT_CHK = 10'b01_0000_0000,
      S_FLUSH    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [JW-1:0] idx_ff, idx_in;
   logic [SW-1:0] addr_ff, addr_in;
   logic first_ff, first_in;
   logic [KW-1:0] prev_key_ff, prev_key_in;
   logic best_valid_ff, best_valid_in;
   logic [KW-1:0] best_key_ff, best_key_in;
   gdjs_pkg::job_entry_type best_job_ff, best_job_in;
   logic pend_valid_ff, pend_valid_in;
   logic [7:0] pend_id_ff, pend_id_in;
   logic [SW-1:0] pend_slot_ff, pend_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   gdjs_pkg::rsp_type rsp_ff, rsp_in;

   logic job_we;
   gdjs_pkg::job_entry_type job_wdata, job_rdata;
   logic slot_we;
   gdjs_pkg::slot_entry_type slot_wdata, slot_rdata;

   logic [KW-1:0] scan_key;
   logic [DLW-1:0] dl_ext, dl_sat;
   logic [SIW-1:0] pend_slot_ext;
   logic out_free;
   logic cand;
   logic advance;

   assign job_wdata.id       = req_payload.job_id;
   assign job_wdata.deadline = req_payload.job_deadline;
   assign job_wdata.profit   = req_payload.job_profit;

   gdjs_job_mem #(
      .DEPTH (MAX_JOBS),
      .AW    (JW)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (job_we),
      .wr_addr (count_ff[JW-1:0]),
      .wr_data (job_wdata),
      .rd_addr (idx_ff),
      .rd_data (job_rdata)
   );

   gdjs_slot_mem #(
      .DEPTH (MAX_SLOTS),
      .AW    (SW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_we),
      .addr    (addr_ff),
      .wr_data (slot_wdata),
      .rd_data (slot_rdata)
   );

   assign scan_key      = {job_rdata.profit, ~idx_ff};
   assign dl_ext        = DLW'(best_job_ff.deadline);
   assign dl_sat        = (dl_ext > DLW'(MAX_SLOTS)) ? DLW'(MAX_SLOTS) : dl_ext;
   assign pend_slot_ext = SIW'(pend_slot_ff);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      prev_key_in   = prev_key_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_job_in   = best_job_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      job_we        = 1'b0;
      slot_we       = 1'b0;
      slot_wdata    = '0;
      cand          = 1'b0;
      advance       = 1'b1;

      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(MAX_JOBS)) begin
                  job_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_payload.set_last) begin
                  addr_in  = '0;
                  state_in = S_CLEAR;
               end
            end
         end
         S_CLEAR: begin
            slot_we = 1'b1;
            if (addr_ff == SW'(MAX_SLOTS - 1)) begin
               idx_in        = '0;
               first_in      = 1'b1;
               best_valid_in = 1'b0;
               state_in      = S_SCAN_RD;
            end else begin
               addr_in = addr_ff + SW'(1);
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cand = (first_ff || (scan_key < prev_key_ff))
                   && (!best_valid_ff || (scan_key > best_key_ff));
            if (cand) begin
               best_valid_in = 1'b1;
               best_key_in   = scan_key;
               best_job_in   = job_rdata;
            end
            if (CW'(idx_ff) == count_ff - CW'(1)) begin
               if (best_valid_ff || cand) begin
                  state_in = S_PLACE;
               end else begin
                  addr_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_EMIT_RD;
               end
            end else begin
               idx_in   = idx_ff + JW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_PLACE: begin
            prev_key_in   = best_key_ff;
            first_in      = 1'b0;
            best_valid_in = 1'b0;
            idx_in        = '0;
            if (best_job_ff.deadline == 8'd0) begin
               state_in = S_SCAN_RD;
            end else begin
               addr_in  = SW'(dl_sat - DLW'(1));
               state_in = S_SLOT_RD;
            end
         end
         S_SLOT_RD: begin
            state_in = S_SLOT_CHK;
         end
         S_SLOT_CHK: begin
            if (!slot_rdata.taken) begin
               slot_we          = 1'b1;
               slot_wdata.taken = 1'b1;
               slot_wdata.owner = best_job_ff.id;
               state_in         = S_SCAN_RD;
            end else if (addr_ff == '0) begin
               state_in = S_SCAN_RD;
            end else begin
               addr_in  = addr_ff - SW'(1);
               state_in = S_SLOT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_CHK;
         end
         S_EMIT_CHK: begin
            if (slot_rdata.taken) begin
               if (pend_valid_ff) begin
                  if (out_free) begin
                     rsp_in.scheduled_id  = pend_id_ff;
                     rsp_in.slot_index    = pend_slot_ext[5:0];
                     rsp_in.sequence_last = 1'b0;
                     rsp_valid_in         = 1'b1;
                     pend_id_in           = slot_rdata.owner;
                     pend_slot_in         = addr_ff;
                  end else begin
                     advance = 1'b0;
                  end
               end else begin
                  pend_valid_in = 1'b1;
                  pend_id_in    = slot_rdata.owner;
                  pend_slot_in  = addr_ff;
               end
            end
            if (advance) begin
               if (addr_ff == SW'(MAX_SLOTS - 1)) begin
                  state_in = S_FLUSH;
               end else begin
                  addr_in  = addr_ff + SW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               count_in = '0;
               state_in = S_LOAD;
            end else if (out_free) begin
               rsp_in.scheduled_id  = pend_id_ff;
               rsp_in.slot_index    = pend_slot_ext[5:0];
               rsp_in.sequence_last = 1'b1;
               rsp_valid_in         = 1'b1;
               pend_valid_in        = 1'b0;
               count_in             = '0;
               state_in             = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         first_ff      <= 1'b1;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         first_ff      <= first_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      addr_ff      <= addr_in;
      prev_key_ff  <= prev_key_in;
      best_key_ff  <= best_key_in;
      best_job_ff  <= best_job_in;
      pend_id_ff   <= pend_id_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall   = (state_ff != S_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sim/greedy_deadline_job_sequencer_core_tb.sv =====
// Testbench for the greedy deadline job sequencer: job sets driven in, schedules checked.
`timescale 1ns / 1ps

module greedy_deadline_job_sequencer_core_tb;

   localparam int JOB_CAP       = gdjs_pkg::MAX_JOBS_DEF;
   localparam int SLOT_CAP      = gdjs_pkg::MAX_SLOTS_DEF;
   localparam int RANDOM_ITEMS  = 120;
   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 25000;

   class schedule_scoreboard;
      gdjs_pkg::job_entry_type jobs[JOB_CAP];
      int unsigned             job_count = 0;
      gdjs_pkg::rsp_type       slot_queue[$];
      int unsigned             errors = 0;

      task report(input string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      function void note_request(input gdjs_pkg::req_type item);
         int                  order[JOB_CAP];
         logic [SLOT_CAP-1:0] taken;
         logic [7:0]          owner[SLOT_CAP];
         int                  k;
         int                  dl;
         int                  pos;
         int                  last_slot;
         if (job_count < JOB_CAP) begin
            jobs[job_count] = '{id: item.job_id, deadline: item.job_deadline,
                                profit: item.job_profit};
            job_count++;
         end
         if (item.set_last) begin
            for (int i = 0; i < job_count; i++) begin
               k = i;
               while (k > 0 && jobs[order[k-1]].profit < jobs[i].profit) begin
                  order[k] = order[k-1];
                  k--;
               end
               order[k] = i;
            end
            taken = '0;
            for (int i = 0; i < job_count; i++) begin
               dl = jobs[order[i]].deadline;
               if (dl > SLOT_CAP) begin
                  dl = SLOT_CAP;
               end
               pos = dl;
               while (pos > 0 && taken[pos-1]) begin
                  pos--;
               end
               if (pos > 0) begin
                  taken[pos-1] = 1'b1;
                  owner[pos-1] = jobs[order[i]].id;
               end
            end
            last_slot = -1;
            for (int s = 0; s < SLOT_CAP; s++) begin
               if (taken[s]) begin
                  last_slot = s;
               end
            end
            for (int s = 0; s < SLOT_CAP; s++) begin
               if (taken[s]) begin
                  slot_queue.push_back('{scheduled_id: owner[s], slot_index: 6'(s),
                                         sequence_last: (s == last_slot)});
               end
            end
            job_count = 0;
         end
      endfunction

      task check_result(input gdjs_pkg::rsp_type got);
         gdjs_pkg::rsp_type want;
         if (slot_queue.size() == 0) begin
            report($sformatf("unexpected result id %0d slot %0d last %0d",
                             got.scheduled_id, got.slot_index, got.sequence_last));
         end else begin
            want = slot_queue.pop_front();
            if (got.scheduled_id !== want.scheduled_id) begin
               report($sformatf("scheduled_id %0d, want %0d (slot %0d)",
                                got.scheduled_id, want.scheduled_id, want.slot_index));
            end
            if (got.slot_index !== want.slot_index) begin
               report($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
            end
            if (got.sequence_last !== want.sequence_last) begin
               report($sformatf("sequence_last %0d, want %0d (slot %0d)",
                                got.sequence_last, want.sequence_last, want.slot_index));
            end
         end
      endtask
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   gdjs_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   gdjs_pkg::rsp_type rsp_payload;

   int unsigned req_idle_pct  = 9;
   int unsigned rsp_idle_pct  = 9;
   int unsigned hold_requests = 0;
   int unsigned random_sent   = 0;

   schedule_scoreboard sched_sb = new();

   greedy_deadline_job_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sched_sb.note_request(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            sched_sb.check_result(rsp_payload);
         end
      end
   end

   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_request(input gdjs_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic send_job(input logic [7:0] id, input logic [7:0] dl,
                           input logic [15:0] pf, input logic last);
      send_request('{job_id: id, job_deadline: dl, job_profit: pf, set_last: last});
   endtask

   task automatic send_random_set(input int n, input int dl_max, input int pf_max);
      gdjs_pkg::req_type item;
      for (int i = 0; i < n; i++) begin
         item.job_id       = 8'($urandom_range(255));
         item.job_deadline = 8'($urandom_range(dl_max));
         item.job_profit   = 16'($urandom_range(pf_max));
         item.set_last     = (i == n - 1);
         send_request(item);
         random_sent++;
      end
   endtask

   task automatic wait_for_schedule();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sched_sb.slot_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int set_no;
      int n;
      int dl_max;
      int pf_max;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // deadline zero alone: empty schedule
      send_job(8'h00, 8'd0, 16'h0000, 1'b1);
      // equal top profits keep order, drop on no free slot, drop on deadline zero
      send_job(8'hFF, 8'd255, 16'hFFFF, 1'b0);
      send_job(8'h00, 8'd0, 16'h0000, 1'b0);
      send_job(8'h01, 8'd1, 16'd100, 1'b0);
      send_job(8'h02, 8'd1, 16'd100, 1'b0);
      send_job(8'h03, 8'd64, 16'hFFFF, 1'b1);
      // deadlines past the slot count saturate
      send_job(8'h0A, 8'd65, 16'd5, 1'b0);
      send_job(8'h0B, 8'd64, 16'd5, 1'b0);
      send_job(8'h0C, 8'd2, 16'd1, 1'b0);
      send_job(8'h0D, 8'd2, 16'd2, 1'b0);
      send_job(8'h0E, 8'd2, 16'd3, 1'b1);
      send_job(8'hA5, 8'd1, 16'h5A5A, 1'b1);

      set_no = 0;
      while (random_sent < RANDOM_ITEMS || set_no < 8) begin
         req_idle_pct = (set_no >= 3 && set_no < 5) ? 0 : 9;
         rsp_idle_pct = req_idle_pct;
         if (set_no == 2) begin
            wait_for_schedule();
         end
         if (set_no == 6) begin
            hold_requests++;
         end
         if (set_no == 0) begin
            // overfill the job store; the ignored last request still closes the set
            send_random_set(JOB_CAP + 2, 70, 65535);
         end else begin
            n = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            case ($urandom_range(9)) inside
               0:       dl_max = 0;
               [1:3]:   dl_max = 4;
               [4:6]:   dl_max = 12;
               default: dl_max = 255;
            endcase
            pf_max = ($urandom_range(1) == 0) ? 3 : 65535;
            send_random_set(n, dl_max, pf_max);
         end
         set_no++;
      end

      wait_for_schedule();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sched_sb.errors == 0 && sched_sb.slot_queue.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
